// ===== rtl/sfh_pkg.sv =====
// Shared types and constants for the SuperFastHash stream core.
`timescale 1ns / 1ps
`default_nettype none
package sfh_pkg;

    localparam int HashW     = 32;
    localparam int LenW      = 32;
    localparam int WordW     = 32;
    localparam int NbytesW   = 3;
    localparam int InDataW   = 72;   // 67 payload bits padded to whole bytes
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // Mixing operation picked by the front from valid_bytes
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TAIL1,
        OP_TAIL2,
        OP_TAIL3,
        OP_WORD
    } op_t;

    // One classified request as it sits in the queue
    typedef struct packed {
        op_t              op;
        logic             first;
        logic             last;
        logic [LenW-1:0]  length;
        logic [WordW-1:0] data_word;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

// ===== rtl/superfast_hash_stream_core.sv =====
// SuperFastHash (32-bit) stream core: top level.
//
// Input channel s_*: one request per 32-bit message word. s_tdata holds,
// from bit 0 up: length[31:0], data_word[63:32], valid_bytes[66:64], zero pad.
// s_tuser marks the first word (seeds the hash from length), s_tlast the
// final word. m_*: one request per message, m_tdata = hash_value[31:0].
// Throughput: one word per cycle sustained while the receiver takes results;
// the limit is the combinational mixing of each word into the running hash register.
// A final word passes through the queue, is mixed into the first stage
// register, then goes through two avalanche stages before m_tvalid rises.
// A four-entry queue sits between the decoding front and the hashing back;
// s_tready drops only when that queue is full.
// When the receiver stalls, the result register holds and the back end
// freezes; the queue then fills and s_tready falls.
// Reset (aresetn low, synchronous) empties the queue and pipeline and
// clears the running hash to zero.
`timescale 1ns / 1ps
`default_nettype none
module superfast_hash_stream_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // length[31:0], data_word[63:32], valid_bytes[66:64], zero pad [71:67]
    input  wire logic [sfh_pkg::InDataW-1:0] s_tdata,
    // first[0]
    input  wire logic                        s_tuser,
    input  wire logic                        s_tlast,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // hash_value[31:0]
    output logic [sfh_pkg::HashW-1:0]        m_tdata
);
    import sfh_pkg::*;

    q_status_t q_status;
    logic      push, pop;
    entry_t    push_entry, pop_entry;

    sfh_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    sfh_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_status   (q_status)
    );

    sfh_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_entry  (pop_entry),
        .q_status   (q_status),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_status.full))
        else $error("push into a full queue");

    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

    a_no_pop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !pop)
        else $error("back end popped while the result was stalled");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && q_status.empty))
        else $error("state left over after reset");

endmodule
`default_nettype wire

// ===== rtl/sfh_front.sv =====
// Front end: accepts input requests, decodes the mixing operation, pushes the queue.
`timescale 1ns / 1ps
`default_nettype none
module sfh_front (
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [sfh_pkg::InDataW-1:0] s_tdata,
    input  wire logic                   s_tuser,
    input  wire logic                   s_tlast,
    input  wire sfh_pkg::q_status_t     q_status,
    output logic                        push,
    output sfh_pkg::entry_t             push_entry
);
    import sfh_pkg::*;

    logic [NbytesW-1:0] nbytes;
    op_t                op;

    assign nbytes = s_tdata[LenW+WordW +: NbytesW];

    always_comb begin
        unique case (nbytes)
            3'd0:    op = OP_NONE;
            3'd1:    op = OP_TAIL1;
            3'd2:    op = OP_TAIL2;
            3'd3:    op = OP_TAIL3;
            default: op = OP_WORD;   // four or more bytes mix as a full word
        endcase
    end

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    always_comb begin
        push_entry.op        = op;
        push_entry.first     = s_tuser;
        push_entry.last      = s_tlast;
        push_entry.length    = s_tdata[LenW-1:0];
        push_entry.data_word = s_tdata[LenW +: WordW];
    end

endmodule
`default_nettype wire

// ===== rtl/sfh_queue.sv =====
// Small FIFO of decoded requests between front and back.
`timescale 1ns / 1ps
`default_nettype none
module sfh_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire sfh_pkg::entry_t    push_entry,
    input  wire logic               pop,
    output sfh_pkg::entry_t         pop_entry,
    output sfh_pkg::q_status_t      q_status
);
    import sfh_pkg::*;

    entry_t                mem [QueueDepth];
    logic [QueuePtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0]  count_reg, count_next;
    logic                  do_push, do_pop;

    assign q_status.full  = (count_reg == QueueCntW'(QueueDepth));
    assign q_status.empty = (count_reg == '0);
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sfh_back.sv =====
// Back end: running-hash mixing, two-stage avalanche ending in the result register.
`timescale 1ns / 1ps
`default_nettype none
module sfh_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire sfh_pkg::entry_t         pop_entry,
    input  wire sfh_pkg::q_status_t      q_status,
    output logic                         pop,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [sfh_pkg::HashW-1:0]    m_tdata
);
    import sfh_pkg::*;

    function automatic logic [HashW-1:0] sext8(input logic [7:0] b);
        return {{(HashW-8){b[7]}}, b};
    endfunction

    function automatic logic [HashW-1:0] mix(input logic [HashW-1:0] h,
                                             input logic [WordW-1:0] w,
                                             input op_t op);
        logic [HashW-1:0] a, b, c;
        a = '0;
        b = '0;
        c = '0;
        unique case (op)
            OP_WORD: begin
                a = h + {16'b0, w[15:0]};
                b = (a << 16) ^ (({16'b0, w[31:16]} << 11) ^ a);
                c = b + (b >> 11);
            end
            OP_TAIL3: begin
                a = h + {16'b0, w[15:0]};
                a = a ^ (a << 16);
                b = a ^ (sext8(w[23:16]) << 18);
                c = b + (b >> 11);
            end
            OP_TAIL2: begin
                a = h + {16'b0, w[15:0]};
                b = a ^ (a << 11);
                c = b + (b >> 17);
            end
            OP_TAIL1: begin
                a = h + sext8(w[7:0]);
                b = a ^ (a << 10);
                c = b + (b >> 1);
            end
            OP_NONE: begin
                c = h;
            end
            default: begin
                c = h;
            end
        endcase
        return c;
    endfunction

    function automatic logic [HashW-1:0] aval_lo(input logic [HashW-1:0] h);
        logic [HashW-1:0] a;
        a = h ^ (h << 3);
        a = a + (a >> 5);
        a = a ^ (a << 4);
        return a;
    endfunction

    function automatic logic [HashW-1:0] aval_hi(input logic [HashW-1:0] h);
        logic [HashW-1:0] a;
        a = h + (h >> 17);
        a = a ^ (a << 25);
        a = a + (a >> 6);
        return a;
    endfunction

    logic [HashW-1:0] run_hash_reg;
    logic [HashW-1:0] seed, mixed;
    logic             advance;
    logic             s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [HashW-1:0] s1_hash_reg, s2_hash_reg, out_hash_reg;

    // whole back end holds while a result waits on the receiver
    assign advance = !out_valid_reg || m_tready;
    assign pop     = advance && !q_status.empty;

    assign seed  = pop_entry.first ? pop_entry.length : run_hash_reg;
    assign mixed = mix(seed, pop_entry.data_word, pop_entry.op);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_hash_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            if (pop) begin
                run_hash_reg <= pop_entry.last ? '0 : mixed;
            end
            s1_valid_reg  <= pop && pop_entry.last;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_hash_reg  <= mixed;
            s2_hash_reg  <= aval_lo(s1_hash_reg);
            out_hash_reg <= aval_hi(s2_hash_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hash_reg;

endmodule
`default_nettype wire
